FILE: design/sisu_pkg.sv
// sisu_pkg: opcodes, field widths and the per-cell control bundle of the
// small integer set store. No dependencies.
`timescale 1ns / 1ps
package sisu_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned COUNT_W  = 6;

  localparam logic [OPCODE_W-1:0] OP_INSERT       = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT_NODUP = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE       = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_MEMBER       = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR        = 3'd4;

  typedef struct packed {
    logic scan;       // token sits on a live entry this cycle
    logic is_remove;  // shift entries left behind a removed match
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

FILE: design/sisu_cell.sv
// sisu_cell: one storage cell of the set chain; holds one entry, compares it
// against the broadcast key and passes the scan token and hit flag onward.
// Depends on sisu_pkg.
`timescale 1ns / 1ps
module sisu_cell
  import sisu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_ctl_t          ctl,
  input  logic [VALUE_W-1:0] key,
  input  logic               tok_in,
  input  logic               hit_in,
  input  logic [VALUE_W-1:0] right_entry,
  input  logic               wr_sel,
  output logic               tok,
  output logic               hit,
  output logic               match,
  output logic [VALUE_W-1:0] entry
);

  assign match = ctl.scan && tok_in && (entry == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
      hit <= 1'b0;
    end else begin
      tok <= ctl.scan && tok_in;
      hit <= ctl.scan && (hit_in || match);
    end
  end

  // tok/hit high here means the token is at the right neighbor with a match
  // already behind it: pull that neighbor's entry one place left.
  always_ff @(posedge clk) begin
    if (wr_sel) begin
      entry <= key;
    end else if (ctl.scan && ctl.is_remove && tok && hit) begin
      entry <= right_entry;
    end
  end

endmodule

FILE: design/sisu_ctrl.sv
// sisu_ctrl: sequencer of the set store; takes input beats, steps the scan
// token along the cell chain, keeps the count and holds the result beat.
// Depends on sisu_pkg.
`timescale 1ns / 1ps
module sisu_ctrl
  import sisu_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OPCODE_W-1:0]        opcode,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       found,
  output logic [COUNT_W-1:0]         count,
  output logic                       full_res,
  input  logic                       match_any,
  output cell_ctl_t                  ctl,
  output logic                       tok0,
  output logic [VALUE_W-1:0]         key,
  output logic                       wr_en,
  output logic [$clog2(CAPACITY+1)-1:0] cnt
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_t              state;
  logic [OPCODE_W-1:0] op;
  logic [CW-1:0]       pos;
  logic [CW-1:0]       cnt_next;
  logic                hit_acc;
  logic                accept;
  logic                needs_scan;
  logic                scan;
  logic                fin;
  logic                not_full;
  logic                found_f;
  logic                full_f;
  logic                wr_f;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign in_stall   = (state == ST_SCAN);
  assign accept     = in_valid && !in_stall;
  assign needs_scan = (op == OP_INSERT) || (op == OP_REMOVE) || (op == OP_MEMBER);
  assign scan       = (state == ST_SCAN) && needs_scan && (pos < cnt);
  assign fin        = (state == ST_SCAN) && !scan && (!out_valid || !out_stall);
  assign not_full   = (cnt < CW'(CAPACITY));

  assign ctl.scan      = scan;
  assign ctl.is_remove = (op == OP_REMOVE);
  assign wr_en         = fin && wr_f;
  assign cnt_ext       = {{COUNT_W{1'b0}}, cnt_next};

  always_comb begin
    found_f  = 1'b0;
    full_f   = 1'b0;
    wr_f     = 1'b0;
    cnt_next = cnt;
    unique case (op)
      OP_INSERT: begin
        found_f = hit_acc;
        if (!hit_acc) begin
          if (not_full) begin
            wr_f     = 1'b1;
            cnt_next = CW'(cnt + 1'b1);
          end else begin
            full_f = 1'b1;
          end
        end
      end
      OP_INSERT_NODUP: begin
        if (not_full) begin
          wr_f     = 1'b1;
          cnt_next = CW'(cnt + 1'b1);
        end else begin
          full_f = 1'b1;
        end
      end
      OP_REMOVE: begin
        found_f = hit_acc;
        if (hit_acc) begin
          cnt_next = CW'(cnt - 1'b1);
        end
      end
      OP_MEMBER: begin
        found_f = hit_acc;
      end
      OP_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      tok0      <= 1'b0;
    end else begin
      tok0 <= accept;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (fin) begin
            state <= ST_IDLE;
            cnt   <= cnt_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= opcode;
      key     <= $unsigned(value);
      pos     <= '0;
      hit_acc <= 1'b0;
    end else if (scan) begin
      pos     <= CW'(pos + 1'b1);
      hit_acc <= hit_acc || match_any;
    end
    if (fin) begin
      found    <= found_f;
      full_res <= full_f;
      count    <= cnt_ext[COUNT_W-1:0];
    end
  end

endmodule

FILE: design/small_integer_set_store_unit.sv
// Small integer set store: an unordered set of up to CAPACITY 32-bit values
// held in a chain of cells, with insert, insert without duplicate check,
// remove, member test and clear; one result beat per input beat reports
// whether the value was present, the new count (low 6 bits) and whether an
// insert was refused because the set was full. For insert, remove and member
// test the scan token steps one cell per cycle over the live entries, and a
// remove shifts the entries behind the match one cell left as it passes.
// A new input beat is taken while a finished result still waits.
// Depends on sisu_pkg, sisu_ctrl and sisu_cell.
`timescale 1ns / 1ps
module small_integer_set_store_unit
  import sisu_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OPCODE_W-1:0]       opcode,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      found,
  output logic [COUNT_W-1:0]        count,
  output logic                      full_res
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  cell_ctl_t           ctl;
  logic                tok0;
  logic [VALUE_W-1:0]  key;
  logic                wr_en;
  logic [CW-1:0]       cnt;
  logic [CAPACITY-1:0] tok;
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] match;
  logic [VALUE_W-1:0]  entry [CAPACITY];

  sisu_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .count     (count),
    .full_res  (full_res),
    .match_any (|match),
    .ctl       (ctl),
    .tok0      (tok0),
    .key       (key),
    .wr_en     (wr_en),
    .cnt       (cnt)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic               tok_in;
    logic               hit_in;
    logic [VALUE_W-1:0] right_entry;
    logic               wr_sel;

    if (k == 0) begin : g_head
      assign tok_in = tok0;
      assign hit_in = 1'b0;
    end else begin : g_body
      assign tok_in = tok[k-1];
      assign hit_in = hit[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = entry[k+1];
    end

    assign wr_sel = wr_en && (cnt == CW'(k));

    sisu_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .key         (key),
      .tok_in      (tok_in),
      .hit_in      (hit_in),
      .right_entry (right_entry),
      .wr_sel      (wr_sel),
      .tok         (tok[k]),
      .hit         (hit[k]),
      .match       (match[k]),
      .entry       (entry[k])
    );
  end

endmodule

FILE: design/sisu_checker.sv
// sisu_checker: port-level assertions for the small integer set store, bound
// to small_integer_set_store_unit. Depends on sisu_pkg.
`timescale 1ns / 1ps
module sisu_checker
  import sisu_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [OPCODE_W-1:0]       opcode,
  input logic signed [VALUE_W-1:0] value,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      found,
  input logic [COUNT_W-1:0]        count,
  input logic                      full_res
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY > 63) || (32'(count) <= CAPACITY))
    else $error("count beat above capacity");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && full_res) |-> !found)
    else $error("refused insert reported a present value");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && full_res) |-> (count == COUNT_W'(CAPACITY)))
    else $error("refused insert with set not full");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(count) && $stable(found)
      && $stable(full_res))
    else $error("stalled result beat changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> in_valid && $stable(opcode) && $stable(value))
    else $error("stalled input beat changed");

endmodule

bind small_integer_set_store_unit sisu_checker #(.CAPACITY(CAPACITY)) u_sisu_checker (.*);
